// File: rtl/core/lgph_pkg.sv
// ----------------------------------------------------------------------------
// lgph_pkg
// Shared types, constants and word tables for the legacy game password hash.
// ----------------------------------------------------------------------------
package lgph_pkg;

  // Three lanes: the fourth password word changes no digest byte
  localparam int unsigned NUM_LANES      = 3;
  localparam int unsigned BYTES_PER_LANE = 4;
  localparam int unsigned WORD_W         = 32;
  localparam int unsigned BYTE_W         = 8;

  // Chain value in compact form: bits 7..0 as is, bit 8 as is, bit 9 stands
  // for bits 9..55, which the split values only ever set all together
  localparam int unsigned EXT_W = 10;

  // Divisor of the split and the substitute for an all-zero chain value
  localparam logic [16:0]       SPLIT_DIV  = 17'd65535;
  localparam logic [BYTE_W-1:0] ZERO_SUBST = 8'd102;

  typedef logic [1:0]                    lane_idx_t;
  typedef logic [EXT_W-1:0]              ext_t;
  typedef ext_t [BYTES_PER_LANE-1:0]     lane_pfx_t;
  typedef lane_pfx_t [NUM_LANES-1:0]     all_pfx_t;

  // Load enables for the two lane stages
  typedef struct packed {
    logic s1_load;
    logic s2_load;
  } lane_ctrl_t;

  // Per-word multiplier
  function automatic logic [WORD_W-1:0] word_mul(lane_idx_t idx);
    logic [WORD_W-1:0] m;
    unique case (idx)
      2'd0: m = 32'd213119;
      2'd1: m = 32'd213247;
      2'd2: m = 32'd213203;
      2'd3: m = 32'd213821;
    endcase
    return m;
  endfunction

  // Per-word addend
  function automatic logic [WORD_W-1:0] word_add(lane_idx_t idx);
    logic [WORD_W-1:0] a;
    unique case (idx)
      2'd0: a = 32'd2529077;
      2'd1: a = 32'd2529089;
      2'd2: a = 32'd229589;
      2'd3: a = 32'd2529997;
    endcase
    return a;
  endfunction

endpackage

// File: rtl/core/lgph_lane.sv
// ----------------------------------------------------------------------------
// lgph_lane
// One password word: multiply-add in stage 1, split into four values and
// local XOR prefix over the word's bytes in stage 2.
// ----------------------------------------------------------------------------
module lgph_lane (
  input  logic                          clk_i,
  input  lgph_pkg::lane_ctrl_t          ctrl_i,
  input  lgph_pkg::lane_idx_t           lane_idx_i,
  input  logic [lgph_pkg::WORD_W-1:0]   word_i,
  output lgph_pkg::lane_pfx_t           pfx_o
);
  import lgph_pkg::*;

  logic [WORD_W-1:0] word_q;
  logic [WORD_W-1:0] v_q;
  logic [WORD_W-1:0] v_d;
  logic [15:0]       rem_lo;
  logic [7:0]        quo_hi;
  logic [16:0]       rem_sum;
  logic              wrap;
  ext_t              kv   [BYTES_PER_LANE];
  ext_t              elem [BYTES_PER_LANE];
  lane_pfx_t         pfx_d;
  lane_pfx_t         pfx_q;

  // Multiply-add modulo 2^32
  assign v_d = word_i * word_mul(lane_idx_i) + word_add(lane_idx_i);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s1_load) begin
      word_q <= word_i;
      v_q    <= v_d;
    end
  end

  // Split: low 24 bits divided by 65535 through one compare; when the
  // quotient rounds up, the remainder goes negative and wraps
  assign rem_lo  = v_q[15:0];
  assign quo_hi  = v_q[23:16];
  assign rem_sum = {9'd0, quo_hi} + {1'b0, rem_lo};
  assign wrap    = (rem_sum >= SPLIT_DIV);

  always_comb begin
    kv[0] = {2'b00, rem_lo[7:0]};
    kv[1] = wrap ? {EXT_W{1'b1}} : {2'b00, rem_lo[15:8]};
    kv[2] = {1'b0, {1'b0, quo_hi} + {8'd0, wrap}};
    kv[3] = {2'b00, v_q[31:24]};
    for (int j = 0; j < BYTES_PER_LANE; j++) begin
      elem[j] = {2'b00, word_q[BYTE_W*j +: BYTE_W]} ^ kv[j];
    end
    // Local prefix over the four bytes of this word
    pfx_d[0] = elem[0];
    for (int j = 1; j < BYTES_PER_LANE; j++) begin
      pfx_d[j] = pfx_d[j-1] ^ elem[j];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s2_load) begin
      pfx_q <= pfx_d;
    end
  end

  assign pfx_o = pfx_q;

endmodule

// File: rtl/core/lgph_merge.sv
// ----------------------------------------------------------------------------
// lgph_merge
// Carries each lane's running XOR into the next lanes, replaces all-zero
// chain values and registers the 12-byte digest.
// ----------------------------------------------------------------------------
module lgph_merge (
  input  logic                  clk_i,
  input  logic                  load_i,
  input  lgph_pkg::all_pfx_t    pfx_i,
  output logic [63:0]           digest_low_o,
  output logic [31:0]           digest_high_o
);
  import lgph_pkg::*;

  localparam int unsigned NUM_BYTES = NUM_LANES * BYTES_PER_LANE;

  ext_t                               carry [NUM_LANES];
  ext_t                               chain;
  logic [NUM_BYTES*BYTE_W-1:0]        digest_d;
  logic [NUM_BYTES*BYTE_W-1:0]        digest_q;

  always_comb begin
    // Running XOR entering each lane
    carry[0] = '0;
    for (int l = 1; l < NUM_LANES; l++) begin
      carry[l] = carry[l-1] ^ pfx_i[l-1][BYTES_PER_LANE-1];
    end
    digest_d = '0;
    chain    = '0;
    for (int l = 0; l < NUM_LANES; l++) begin
      for (int j = 0; j < BYTES_PER_LANE; j++) begin
        chain = pfx_i[l][j] ^ carry[l];
        digest_d[BYTE_W*(l*BYTES_PER_LANE + j) +: BYTE_W] =
          (chain == '0) ? ZERO_SUBST : chain[BYTE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      digest_q <= digest_d;
    end
  end

  assign digest_low_o  = digest_q[63:0];
  assign digest_high_o = digest_q[95:64];

endmodule

// File: rtl/core/legacy_game_password_hash.sv
// An input transfer passes the registered multiply, split and merge stages in order.
// Throughput: one item per cycle while out_stall_i does not hold the output; three
// lanes, one per password word, each with one 32-bit multiplier, run side by side
// and a merge stage joins them.
// Each stage advances when empty or when the stage after it advances.
// Reset clears the stage valid bits only; no result is pending after reset.
// ----------------------------------------------------------------------------
// legacy_game_password_hash
// Legacy game-server password digest: 16 password bytes in, 12 bytes out.
// ----------------------------------------------------------------------------
module legacy_game_password_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] password_low_i,
  input  logic [63:0] password_high_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] digest_low_o,
  output logic [31:0] digest_high_o
);
  import lgph_pkg::*;

  logic       s1_v_q;
  logic       s2_v_q;
  logic       out_v_q;
  logic       out_rdy;
  logic       s2_rdy;
  logic       s1_rdy;
  logic       in_xfer;
  lane_ctrl_t ctrl;
  all_pfx_t   pfx;
  logic [WORD_W-1:0] words [NUM_LANES];

  // Stage readiness, from the output back to the input
  assign out_rdy = !out_v_q || !out_stall_i;
  assign s2_rdy  = !s2_v_q || out_rdy;
  assign s1_rdy  = !s1_v_q || s2_rdy;
  assign in_xfer = in_valid_i && s1_rdy;

  assign in_stall_o   = !s1_rdy;
  assign out_valid_o  = out_v_q;
  assign ctrl.s1_load = in_xfer;
  assign ctrl.s2_load = s1_v_q && s2_rdy;

  // Advance stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_rdy)  s1_v_q  <= in_valid_i;
      if (s2_rdy)  s2_v_q  <= s1_v_q;
      if (out_rdy) out_v_q <= s2_v_q;
    end
  end

  // Little-endian words of the first 12 bytes
  assign words[0] = password_low_i[31:0];
  assign words[1] = password_low_i[63:32];
  assign words[2] = password_high_i[31:0];

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    lgph_lane u_lane (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .lane_idx_i (lane_idx_t'(l)),
      .word_i     (words[l]),
      .pfx_o      (pfx[l])
    );
  end

  lgph_merge u_merge (
    .clk_i         (clk_i),
    .load_i        (s2_v_q && out_rdy),
    .pfx_i         (pfx),
    .digest_low_o  (digest_low_o),
    .digest_high_o (digest_high_o)
  );

  // Input is held off only when every stage is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_v_q && s2_v_q && out_v_q))
    else $error("input stalled with a free stage");

  // An accepted item lands in stage 1
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> s1_v_q)
    else $error("accepted item lost at stage 1");

  // A new result only comes from a filled stage 2
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(s2_v_q))
    else $error("result without a stage 2 item");

endmodule

// File: tb/legacy_game_password_hash_tb.sv
// ----------------------------------------------------------------------------
// legacy_game_password_hash_tb
// Self-checking bench for the legacy password digest. Each password transfer
// is hashed by a behavioral model and queued; each digest transfer is checked
// field by field against the oldest queued digest. Directed cases cover field
// extremes, embedded zero bytes, the divisor wrap and zero substitution; a
// long random phase follows with random idling on both sides, one long output
// hold-off and one full drain.
// ----------------------------------------------------------------------------
module legacy_game_password_hash_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_ITEMS = 830;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned SEARCH_TRIES = 200000;

  // --------------------------------------------------------------------------
  // Digest model and queue of expected digests
  // --------------------------------------------------------------------------
  class digest_scoreboard;
    logic [63:0] want_low_q[$];
    logic [31:0] want_high_q[$];
    int          errors;

    function new();
      errors = 0;
    endfunction

    // Per-word multiplier and addend
    function void lane_consts(input int unsigned lane, output logic [31:0] mul,
                              output logic [31:0] add);
      case (lane)
        0: begin
          mul = 32'd213119;
          add = 32'd2529077;
        end
        1: begin
          mul = 32'd213247;
          add = 32'd2529089;
        end
        2: begin
          mul = 32'd213203;
          add = 32'd229589;
        end
        default: begin
          mul = 32'd213821;
          add = 32'd2529997;
        end
      endcase
    endfunction

    // Hash one password; also count substituted and low-byte-only zero links
    function void predict_digest(input logic [63:0] pw_low, input logic [63:0] pw_high,
                                 output logic [63:0] dig_low, output logic [31:0] dig_high,
                                 output int zero_subs, output int masked_zeros);
      logic [7:0]  pw_bytes[16];
      logic [63:0] keys[16];
      logic [31:0] mul;
      logic [31:0] add;
      logic [31:0] v32;
      logic [63:0] v;
      logic [63:0] top;
      logic [63:0] rem;
      logic [63:0] third;
      logic [63:0] second;
      logic [63:0] link;
      logic [7:0]  out_byte;
      zero_subs    = 0;
      masked_zeros = 0;
      dig_low      = '0;
      dig_high     = '0;
      for (int i = 0; i < 8; i++) begin
        pw_bytes[i]     = pw_low[8*i +: 8];
        pw_bytes[i + 8] = pw_high[8*i +: 8];
      end
      // Scramble each word, then split it with 64-bit wrapping arithmetic
      for (int w = 0; w < 4; w++) begin
        lane_consts(w, mul, add);
        v32    = {pw_bytes[4*w+3], pw_bytes[4*w+2], pw_bytes[4*w+1], pw_bytes[4*w]} * mul
                 + add;
        v      = {32'd0, v32};
        top    = v >> 24;
        rem    = v - (top << 24);
        third  = rem / 64'd65535;
        second = (rem - (third << 16)) / 64'd256;
        keys[4*w]     = rem - (third << 16) - (second << 8);
        keys[4*w + 1] = second;
        keys[4*w + 2] = third;
        keys[4*w + 3] = top;
      end
      // Run the XOR chain; substitute 102 only where all 64 bits are zero
      link = 64'd0;
      for (int i = 0; i < 12; i++) begin
        link = {56'd0, pw_bytes[i]} ^ link ^ keys[i];
        if (link == 64'd0) begin
          out_byte = 8'd102;
          zero_subs++;
        end else begin
          out_byte = link[7:0];
          if (out_byte == 8'd0) masked_zeros++;
        end
        if (i < 8) dig_low[8*i +: 8] = out_byte;
        else dig_high[8*(i-8) +: 8] = out_byte;
      end
    endfunction

    function void note_password(input logic [63:0] pw_low, input logic [63:0] pw_high);
      logic [63:0] dig_low;
      logic [31:0] dig_high;
      int          zero_subs;
      int          masked_zeros;
      predict_digest(pw_low, pw_high, dig_low, dig_high, zero_subs, masked_zeros);
      want_low_q.push_back(dig_low);
      want_high_q.push_back(dig_high);
    endfunction

    function void check_digest(input logic [63:0] got_low, input logic [31:0] got_high);
      logic [63:0] want_low;
      logic [31:0] want_high;
      if (want_low_q.size() == 0) begin
        $display("%0t: digest with nothing pending: low %h high %h",
                 $time, got_low, got_high);
        errors++;
      end else begin
        want_low  = want_low_q.pop_front();
        want_high = want_high_q.pop_front();
        if (got_low !== want_low) begin
          $display("%0t: digest_low expected %h actual %h", $time, want_low, got_low);
          errors++;
        end
        if (got_high !== want_high) begin
          $display("%0t: digest_high expected %h actual %h", $time, want_high, got_high);
          errors++;
        end
      end
    endfunction

    function int pending();
      return want_low_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and block under test
  // --------------------------------------------------------------------------
  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic [63:0] password_low_i  = '0;
  logic [63:0] password_high_i = '0;
  logic        out_stall_i     = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [63:0] digest_low_o;
  logic [31:0] digest_high_o;

  digest_scoreboard digests;
  bit               tx_idle_on = 1'b0;
  bit               rx_idle_on = 1'b0;
  bit               hold_req   = 1'b0;
  int unsigned      hold_cnt   = 0;
  int unsigned      burst_cnt  = 0;
  int unsigned      cycle_cnt  = 0;

  legacy_game_password_hash dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .password_low_i (password_low_i),
    .password_high_i(password_high_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .digest_low_o   (digest_low_o),
    .digest_high_o  (digest_high_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("legacy_game_password_hash_tb: done, errors");
      $finish;
    end else begin
      cycle_cnt <= cycle_cnt + 1;
    end
  end

  // Check each digest transfer, then pick the next stall value
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      digests.check_digest(digest_low_o, digest_high_o);
    end
    if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = HOLD_CYCLES;
    end
    if (hold_cnt != 0) begin
      hold_cnt--;
      out_stall_i <= 1'b1;
    end else if (burst_cnt != 0) begin
      burst_cnt--;
      out_stall_i <= 1'b1;
    end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
      burst_cnt = $urandom_range(0, 8);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Offer one password and hold it until the transfer
  task automatic send_password(input logic [63:0] pw_low, input logic [63:0] pw_high);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    password_low_i  <= pw_low;
    password_high_i <= pw_high;
    do @(posedge clk_i); while (in_stall_o);
    digests.note_password(pw_low, pw_high);
  endtask

  // Drop valid and wait for every pending digest
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (digests.pending() != 0);
  endtask

  // Invert the word scramble: find the word that maps to value v
  function automatic logic [31:0] word_for_value(input int unsigned lane,
                                                 input logic [31:0] v);
    logic [31:0] mul;
    logic [31:0] add;
    logic [31:0] inv;
    digests.lane_consts(lane, mul, add);
    inv = mul;
    repeat (5) inv = inv * (32'd2 - mul * inv);
    return (v - add) * inv;
  endfunction

  // Force the divisor wrap on the selected lanes: bits 23..8 of the value all set
  function automatic void quirk_password(input logic [2:0] lanes,
                                         output logic [63:0] pw_low,
                                         output logic [63:0] pw_high);
    logic [31:0] words[4];
    logic [31:0] v;
    for (int w = 0; w < 4; w++) begin
      v        = $urandom;
      v[23:8]  = 16'hFFFF;
      words[w] = (w < 3 && lanes[w]) ? word_for_value(w, v) : 32'($urandom);
    end
    pw_low  = {words[1], words[0]};
    pw_high = {words[3], words[2]};
  endfunction

  // Draw a random password from a mix of shapes
  function automatic void random_password(output logic [63:0] pw_low,
                                          output logic [63:0] pw_high);
    logic [7:0]  b[16];
    int unsigned len;
    int unsigned mode;
    mode = $urandom_range(0, 9);
    len  = $urandom_range(0, 16);
    for (int i = 0; i < 16; i++) begin
      case (mode)
        5:       b[i] = (i < len) ? 8'($urandom_range(1, 255)) : 8'd0;
        6:       b[i] = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom);
        9: begin
          case ($urandom_range(0, 3))
            0:       b[i] = 8'h00;
            1:       b[i] = 8'hFF;
            2:       b[i] = 8'h80;
            default: b[i] = 8'h01;
          endcase
        end
        default: b[i] = 8'($urandom);
      endcase
    end
    for (int i = 0; i < 8; i++) begin
      pw_low[8*i +: 8]  = b[i];
      pw_high[8*i +: 8] = b[i + 8];
    end
    if (mode == 7 || mode == 8) begin
      quirk_password(3'($urandom_range(1, 7)), pw_low, pw_high);
    end
  endfunction

  // Look for a password that substitutes a zero link, or one whose wrapped
  // link is zero in the low byte only
  function automatic void search_password(input bit want_masked,
                                          output logic [63:0] pw_low,
                                          output logic [63:0] pw_high);
    logic [63:0] dig_low;
    logic [31:0] dig_high;
    int          zero_subs;
    int          masked_zeros;
    for (int n = 0; n < SEARCH_TRIES; n++) begin
      if (want_masked) quirk_password(3'b111, pw_low, pw_high);
      else random_password(pw_low, pw_high);
      digests.predict_digest(pw_low, pw_high, dig_low, dig_high, zero_subs, masked_zeros);
      if (want_masked ? (masked_zeros > 0) : (zero_subs > 0)) break;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [63:0] pw_low;
    logic [63:0] pw_high;
    digests = new();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Field extremes and plain text
    send_password(64'd0, 64'd0);
    send_password('1, '1);
    send_password('1, 64'd0);
    send_password(64'd0, '1);
    send_password(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    send_password(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    send_password(64'h0000_0000_0000_0061, 64'd0);
    send_password(64'h6472_6F77_7373_6170, 64'd0);
    send_password(64'h6867_6665_6463_6261, 64'h706F_6E6D_6C6B_6A69);

    // Leading zero byte with text after it; then vary bytes 13..16 only
    send_password(64'h6867_6665_6463_6200, 64'h706F_6E6D_6C6B_6A69);
    send_password(64'h6867_6665_6463_6200, 64'hFFFF_FFFF_6C6B_6A69);
    send_password(64'h6867_6665_6463_6200, 64'h8000_0000_6C6B_6A69);

    // Divisor wrap on each lane, on all lanes, and just below the wrap
    for (int lane = 0; lane < 3; lane++) begin
      quirk_password(3'(1 << lane), pw_low, pw_high);
      send_password(pw_low, pw_high);
    end
    quirk_password(3'b111, pw_low, pw_high);
    send_password(pw_low, pw_high);
    send_password({32'($urandom), word_for_value(0, 32'h12FF_FEFF)},
                  {32'($urandom), 32'($urandom)});

    // Scrambled values at their extremes
    send_password({word_for_value(1, 32'hFFFF_FFFF), word_for_value(0, 32'hFFFF_FFFF)},
                  {32'($urandom), word_for_value(2, 32'hFFFF_FFFF)});
    send_password({word_for_value(1, 32'd0), word_for_value(0, 32'd0)},
                  {32'($urandom), word_for_value(2, 32'd0)});

    // Zero substitution and a wrapped link that is zero in its low byte only
    search_password(1'b0, pw_low, pw_high);
    send_password(pw_low, pw_high);
    search_password(1'b1, pw_low, pw_high);
    send_password(pw_low, pw_high);

    wait_drained();

    // Random phase
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 100) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      if (n == 200) begin
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
      end
      // Hold the output off while the sender keeps offering
      if (n == 300) begin
        tx_idle_on = 1'b0;
        hold_req   = 1'b1;
      end
      if (n == 360) tx_idle_on = 1'b1;
      if (n == 500) wait_drained();
      if (n == RANDOM_ITEMS - 120) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      random_password(pw_low, pw_high);
      send_password(pw_low, pw_high);
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (digests.errors == 0) begin
      $display("legacy_game_password_hash_tb: done, clean");
    end else begin
      $display("legacy_game_password_hash_tb: done, errors");
    end
    $finish;
  end

endmodule
